[src/smt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted multi-timer package
// Word types, codes and sequencer states shared by the timer block.
// ---------------------------------------------------------------------------
package smt_pkg;

   localparam int TIME_W  = 48;
   localparam int ID_W    = 4;
   localparam int CNT_W   = 16;
   localparam int TMO_W   = 32;
   localparam int CFG_W   = 5;
   localparam int MAX_IDS = 16;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_SET    = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;

   localparam logic KIND_REPLY  = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam logic [CFG_W-1:0] TIMERS_IN_USE_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]       mode;
      logic [ID_W-1:0]  timer_id;
      logic [TMO_W-1:0] timeout_ticks;
   } req_word_type;

   typedef struct packed {
      logic             kind;
      logic             status;
      logic [ID_W-1:0]  fired_id;
      logic [CNT_W-1:0] timeout_count;
      logic             last;
   } rsp_word_type;

   typedef struct packed {
      logic [TIME_W-1:0] sum;
      logic              neg;
      logic              zero;
      logic              below_key;
   } arith_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SET_RD,
      ST_SET_CMP,
      ST_CAN,
      ST_TICK_RD,
      ST_TICK_CMP,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      LIST_NONE,
      LIST_INSERT,
      LIST_REMOVE
   } list_op_type;

endpackage

[src/smt_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module smt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/smt_arith.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shared time arithmetic unit
// One 48-bit adder/subtractor with sign, zero and key compare flags.
// ---------------------------------------------------------------------------
module smt_arith (
   input  logic [smt_pkg::TIME_W-1:0] op_a,
   input  logic [smt_pkg::TIME_W-1:0] op_b,
   input  logic                       sub,
   input  logic [smt_pkg::TIME_W-1:0] key,
   output smt_pkg::arith_res_type     res
);
   import smt_pkg::*;

   logic [TIME_W-1:0] b_eff;
   logic [TIME_W-1:0] sum;

   // The key is never negative, so a non-negative sum compares unsigned.
   always_comb begin
      b_eff         = sub ? ~op_b : op_b;
      sum           = op_a + b_eff + TIME_W'(sub);
      res.sum       = sum;
      res.neg       = sum[TIME_W-1];
      res.zero      = (sum == '0);
      res.below_key = sum[TIME_W-1] || (sum < key);
   end

endmodule

[src/sorted_multi_timer.sv]
`timescale 1ns / 1ps
// A set walks the list from its head until it finds its place or reaches the list end, a cancel
// walks the list until it finds its id, and a rejected set or cancel goes straight to its reply.
// A tick scans every armed timer and sends the last expiry word once the scan ends; result
// stalls can hold any of these. One word at a time: the next is taken once the block is back in
// idle. Reset is synchronous and clears all timers, counts and the clock at once; no clearing pass.
// ---------------------------------------------------------------------------
// Sorted multi-timer
// A bank of one-shot timers kept in a list ordered by expiry time, with
// set, cancel and tick commands and one expiry word per fired timer.
// ---------------------------------------------------------------------------
module sorted_multi_timer #(
   parameter int TIMER_COUNT = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  smt_pkg::req_word_type     req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output smt_pkg::rsp_word_type     rsp_word,
   input  logic                      csr_we,
   input  logic [smt_pkg::CFG_W-1:0] csr_wdata
);
   import smt_pkg::*;

   // Timer storage is TIMER_COUNT deep, but ids are four bits wide, so the
   // ordered list never holds more than sixteen entries.
   localparam int IDX_W      = $clog2(TIMER_COUNT);
   localparam int LIST_DEPTH = (TIMER_COUNT < MAX_IDS) ? TIMER_COUNT : MAX_IDS;
   localparam int TOT_W      = $clog2(LIST_DEPTH + 1);
   localparam int POS_W      = $clog2(LIST_DEPTH);

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   state_type         state_ff, state_in;
   req_word_type      cmd_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIMER_COUNT-1:0] armed_ff;
   logic [TIMER_COUNT-1:0] cnt_vld_ff;
   logic [ID_W-1:0]   order_ff [LIST_DEPTH];
   logic [ID_W-1:0]   order_in [LIST_DEPTH];
   logic [TOT_W-1:0]  total_ff;
   logic [TOT_W-1:0]  r_ff;
   logic              pend_vld_ff;
   rsp_word_type      pend_ff;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_word_ff;
   logic [CFG_W-1:0]  tiu_ff;

   // ---------------------------------------------------------------------
   // Decode of the held command and the list entry under the scan pointer
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0]  cmd_idx;
   logic              r_live;
   logic [ID_W-1:0]   cur_id;
   logic [IDX_W-1:0]  cur_idx;
   logic [CFG_W-1:0]  limit;
   logic              id_ok;
   logic              id_exists;
   logic              list_full;
   logic              set_ok;
   logic              cancel_ok;
   logic              is_set;
   logic              is_cancel;
   logic              is_tick;
   logic              cur_cnt_vld;
   logic [CNT_W-1:0]  cur_cnt;
   logic [CNT_W-1:0]  inc_cnt;
   logic              out_free;
   logic              due;
   logic              hit;

   logic [TIME_W-1:0] exp_rdata;
   logic [CNT_W-1:0]  cnt_rdata;
   arith_res_type     ar_res;

   assign cmd_idx   = IDX_W'(cmd_ff.timer_id);
   assign r_live    = (r_ff < total_ff);
   assign cur_id    = r_live ? order_ff[r_ff[POS_W-1:0]] : '0;
   assign cur_idx   = IDX_W'(cur_id);

   // The usable limit is the smaller of the register and the list depth.
   assign limit     = (tiu_ff > CFG_W'(LIST_DEPTH)) ? CFG_W'(LIST_DEPTH) : tiu_ff;
   assign id_ok     = (CFG_W'(cmd_ff.timer_id) < limit);
   assign id_exists = (32'(cmd_ff.timer_id) < 32'(TIMER_COUNT));
   assign list_full = (32'(total_ff) >= 32'(TIMER_COUNT));

   assign is_set    = (cmd_ff.mode == MODE_SET);
   assign is_cancel = (cmd_ff.mode == MODE_CANCEL);
   assign is_tick   = (cmd_ff.mode == MODE_TICK);
   assign cancel_ok = id_ok && armed_ff[cmd_idx];
   assign set_ok    = id_ok && !armed_ff[cmd_idx] && !list_full;

   // A count that was never written since reset reads as zero. An id with
   // no timer behind it also reports zero.
   assign cur_cnt_vld = (state_ff == ST_DECIDE) ? (id_exists && cnt_vld_ff[cmd_idx])
                                                : cnt_vld_ff[cur_idx];
   assign cur_cnt  = cur_cnt_vld ? cnt_rdata : '0;
   assign inc_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + CNT_W'(1);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign due      = ar_res.neg || ar_res.zero;
   assign hit      = (cur_id == cmd_ff.timer_id);

   // ---------------------------------------------------------------------
   // Sequencer control
   // ---------------------------------------------------------------------
   logic [TIME_W-1:0] ar_a;
   logic [TIME_W-1:0] ar_b;
   logic              ar_sub;
   logic              exp_we;
   logic [IDX_W-1:0]  cnt_raddr;
   logic              cnt_we;
   list_op_type       list_op;
   logic              r_step;
   logic              r_clear;
   logic              now_load;
   logic              armed_set;
   logic              armed_clear;
   logic [IDX_W-1:0]  armed_idx;
   logic              pend_load;
   rsp_word_type      pend_word;
   logic              pend_clear;
   logic              push;
   rsp_word_type      push_word;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (is_set) begin
               state_in = set_ok ? ST_SET_RD : ST_FLUSH;
            end else if (is_cancel) begin
               state_in = cancel_ok ? ST_CAN : ST_FLUSH;
            end else if (is_tick) begin
               state_in = ST_TICK_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SET_RD: begin
            state_in = r_live ? ST_SET_CMP : ST_FLUSH;
         end
         ST_SET_CMP: begin
            state_in = ar_res.below_key ? ST_SET_RD : ST_FLUSH;
         end
         ST_CAN: begin
            if (!r_live || hit) begin
               state_in = ST_FLUSH;
            end
         end
         ST_TICK_RD: begin
            priority if (r_live) begin
               state_in = ST_TICK_CMP;
            end else if (pend_vld_ff) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_CMP: begin
            if (!due || !pend_vld_ff || out_free) begin
               state_in = ST_TICK_RD;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_stall   = reset || (state_ff != ST_IDLE);
      ar_a        = exp_rdata;
      ar_b        = now_ff;
      ar_sub      = 1'b1;
      exp_we      = 1'b0;
      cnt_raddr   = (state_ff == ST_IDLE) ? IDX_W'(req_word.timer_id) : cur_idx;
      cnt_we      = 1'b0;
      list_op     = LIST_NONE;
      r_step      = 1'b0;
      r_clear     = 1'b0;
      now_load    = 1'b0;
      armed_set   = 1'b0;
      armed_clear = 1'b0;
      armed_idx   = cmd_idx;
      pend_load   = 1'b0;
      pend_clear  = 1'b0;
      push        = 1'b0;
      pend_word.kind          = KIND_REPLY;
      pend_word.status        = STATUS_OK;
      pend_word.fired_id      = cmd_ff.timer_id;
      pend_word.timeout_count = cur_cnt;
      pend_word.last          = 1'b0;
      push_word      = pend_ff;
      push_word.last = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_DECIDE: begin
            // The adder forms the new expiry for a set, or the next time
            // for a tick.
            ar_a    = now_ff;
            ar_b    = is_tick ? TIME_W'(1) : TIME_W'(cmd_ff.timeout_ticks);
            ar_sub  = 1'b0;
            r_clear = 1'b1;
            if (is_set) begin
               exp_we           = set_ok;
               pend_load        = 1'b1;
               pend_word.status = set_ok ? STATUS_OK : STATUS_REJECT;
            end
            if (is_cancel) begin
               pend_load        = 1'b1;
               pend_word.status = cancel_ok ? STATUS_OK : STATUS_REJECT;
            end
            if (is_tick) begin
               now_load = 1'b1;
            end
         end
         ST_SET_RD: begin
            if (!r_live) begin
               list_op   = LIST_INSERT;
               armed_set = 1'b1;
            end
         end
         ST_SET_CMP: begin
            // A new timer goes ahead of every entry with an equal expiry.
            if (ar_res.below_key) begin
               r_step = 1'b1;
            end else begin
               list_op   = LIST_INSERT;
               armed_set = 1'b1;
            end
         end
         ST_CAN: begin
            if (r_live && hit) begin
               list_op     = LIST_REMOVE;
               armed_clear = 1'b1;
            end else begin
               r_step = 1'b1;
            end
         end
         ST_TICK_RD: begin
         end
         ST_TICK_CMP: begin
            // Each fired timer waits in the pending register until the next
            // one is found or the scan ends, which settles its last flag.
            armed_idx = cur_idx;
            if (!due) begin
               r_step = 1'b1;
            end else if (!pend_vld_ff || out_free) begin
               push        = pend_vld_ff;
               cnt_we      = 1'b1;
               list_op     = LIST_REMOVE;
               armed_clear = 1'b1;
               pend_load   = 1'b1;
               pend_word.kind          = KIND_EXPIRY;
               pend_word.status        = STATUS_OK;
               pend_word.fired_id      = cur_id;
               pend_word.timeout_count = inc_cnt;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               push           = 1'b1;
               push_word.last = 1'b1;
               pend_clear     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Ordered list: insert shifts the tail up, remove closes the gap.
   // ---------------------------------------------------------------------
   always_comb begin
      for (int q = 0; q < LIST_DEPTH; q++) begin
         order_in[q] = order_ff[q];
         unique case (list_op)
            LIST_INSERT: begin
               if (TOT_W'(q) == r_ff) begin
                  order_in[q] = cmd_ff.timer_id;
               end else if (q > 0 && TOT_W'(q) > r_ff && TOT_W'(q) <= total_ff) begin
                  order_in[q] = order_ff[q-1];
               end
            end
            LIST_REMOVE: begin
               if (q < LIST_DEPTH - 1 && TOT_W'(q) >= r_ff) begin
                  order_in[q] = order_ff[q+1];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         armed_ff     <= '0;
         cnt_vld_ff   <= '0;
         total_ff     <= '0;
         r_ff         <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tiu_ff       <= TIMERS_IN_USE_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            tiu_ff <= csr_wdata;
         end
         if (now_load) begin
            now_ff <= ar_res.sum;
         end
         if (armed_set) begin
            armed_ff[armed_idx] <= 1'b1;
         end
         if (armed_clear) begin
            armed_ff[armed_idx] <= 1'b0;
         end
         if (cnt_we) begin
            cnt_vld_ff[cur_idx] <= 1'b1;
         end
         unique case (list_op)
            LIST_INSERT: total_ff <= total_ff + TOT_W'(1);
            LIST_REMOVE: total_ff <= total_ff - TOT_W'(1);
            default:     total_ff <= total_ff;
         endcase
         priority if (r_clear) begin
            r_ff <= '0;
         end else if (r_step) begin
            r_ff <= r_ff + TOT_W'(1);
         end else begin
            r_ff <= r_ff;
         end
         priority if (pend_load) begin
            pend_vld_ff <= 1'b1;
         end else if (pend_clear) begin
            pend_vld_ff <= 1'b0;
         end else begin
            pend_vld_ff <= pend_vld_ff;
         end
         priority if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= rsp_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         cmd_ff <= req_word;
      end
      if (pend_load) begin
         pend_ff <= pend_word;
      end
      if (push) begin
         rsp_word_ff <= push_word;
      end
      order_ff <= order_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------------
   // Shared adder and the two timer RAMs
   // ---------------------------------------------------------------------
   smt_arith u_arith (
      .op_a (ar_a),
      .op_b (ar_b),
      .sub  (ar_sub),
      .key  (TIME_W'(cmd_ff.timeout_ticks)),
      .res  (ar_res)
   );

   smt_ram #(
      .WIDTH (TIME_W),
      .DEPTH (TIMER_COUNT)
   ) u_expiry_ram (
      .clock (clock),
      .we    (exp_we),
      .waddr (cmd_idx),
      .wdata (ar_res.sum),
      .raddr (cur_idx),
      .rdata (exp_rdata)
   );

   smt_ram #(
      .WIDTH (CNT_W),
      .DEPTH (TIMER_COUNT)
   ) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cur_idx),
      .wdata (inc_cnt),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

`ifndef SYNTHESIS
   // The list length always equals the number of armed timers.
   assert property (@(posedge clock) disable iff (reset)
      $countones(armed_ff) == int'(total_ff))
      else $error("armed count and list length disagree");

   assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= 32'(LIST_DEPTH))
      else $error("list overflow");

   // Once the final word is handed on, the block is idle with nothing held.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free) |=> (state_ff == ST_IDLE && !pend_vld_ff))
      else $error("flush did not complete");

   // A word is never pushed over one that is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("output word overwritten");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.kind == KIND_EXPIRY) |-> rsp_word_ff.status == STATUS_OK)
      else $error("expiry word marked rejected");
`endif

endmodule

[verif/smt_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted multi-timer checker
// Watches the request, result and register ports of the timer block, keeps
// its own copy of the timer bank and compares every result word in order.
// ---------------------------------------------------------------------------
module smt_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  smt_pkg::req_word_type     req_word,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  smt_pkg::rsp_word_type     rsp_word,
   input  logic                      csr_we,
   input  logic [smt_pkg::CFG_W-1:0] csr_wdata,
   output int                        fail_count,
   output int                        words_due
);
   import smt_pkg::*;

   logic [CFG_W-1:0]  usable_ids;
   logic [TIME_W-1:0] tick_now;
   logic [TIME_W-1:0] timer_expiry [MAX_IDS];
   logic              timer_armed  [MAX_IDS];
   logic [CNT_W-1:0]  fire_count   [MAX_IDS];
   logic [ID_W-1:0]   queue_order  [MAX_IDS];
   int                armed_n;
   int                mismatches = 0;
   rsp_word_type      due_words [$];

   assign fail_count = mismatches;

   // Distance from now to the expiry, judged as a signed 48-bit number.
   function automatic logic signed [TIME_W-1:0] ticks_left(input logic [ID_W-1:0] id);
      ticks_left = $signed(timer_expiry[id] - tick_now);
   endfunction

   task automatic check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   task automatic clear_bank();
      usable_ids = TIMERS_IN_USE_RESET;
      tick_now   = '0;
      armed_n    = 0;
      for (int k = 0; k < MAX_IDS; k++) begin
         timer_expiry[k] = '0;
         timer_armed[k]  = 1'b0;
         fire_count[k]   = '0;
         queue_order[k]  = '0;
      end
      due_words.delete();
   endtask

   task automatic predict_words(input req_word_type w);
      rsp_word_type             r;
      int                       lim;
      int                       p;
      int                       wr;
      int                       fired;
      logic signed [TIME_W-1:0] key;
      logic [ID_W-1:0]          id;
      logic [ID_W-1:0]          t;
      lim             = (int'(usable_ids) > MAX_IDS) ? MAX_IDS : int'(usable_ids);
      id              = w.timer_id;
      r               = '0;
      r.kind          = KIND_REPLY;
      r.status        = STATUS_OK;
      r.fired_id      = id;
      r.timeout_count = fire_count[id];
      r.last          = 1'b1;
      case (w.mode)
         MODE_SET: begin
            if (int'(id) >= lim || timer_armed[id] || armed_n >= MAX_IDS) begin
               r.status = STATUS_REJECT;
            end else begin
               timer_expiry[id] = tick_now + TIME_W'(w.timeout_ticks);
               key = ticks_left(id);
               // The new timer goes ahead of any with the same expiry.
               p = 0;
               while (p < armed_n && ticks_left(queue_order[p]) < key) p++;
               for (int q = armed_n; q > p; q--) queue_order[q] = queue_order[q-1];
               queue_order[p]  = id;
               timer_armed[id] = 1'b1;
               armed_n++;
            end
            due_words.push_back(r);
         end
         MODE_CANCEL: begin
            if (int'(id) >= lim || !timer_armed[id]) begin
               r.status = STATUS_REJECT;
            end else begin
               wr = 0;
               for (int k = 0; k < armed_n; k++) begin
                  if (queue_order[k] != id) begin
                     queue_order[wr] = queue_order[k];
                     wr++;
                  end
               end
               armed_n         = wr;
               timer_armed[id] = 1'b0;
            end
            due_words.push_back(r);
         end
         MODE_TICK: begin
            tick_now = tick_now + 1'b1;
            fired    = 0;
            wr       = 0;
            for (int k = 0; k < armed_n; k++) begin
               t = queue_order[k];
               if (ticks_left(t) <= 0 && fired < MAX_IDS) begin
                  if (fire_count[t] != '1) fire_count[t] = fire_count[t] + 1'b1;
                  timer_armed[t]  = 1'b0;
                  r.kind          = KIND_EXPIRY;
                  r.status        = STATUS_OK;
                  r.fired_id      = t;
                  r.timeout_count = fire_count[t];
                  r.last          = 1'b0;
                  due_words.push_back(r);
                  fired++;
               end else begin
                  queue_order[wr] = t;
                  wr++;
               end
            end
            armed_n = wr;
            if (fired > 0) begin
               r      = due_words.pop_back();
               r.last = 1'b1;
               due_words.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (reset) begin
         clear_bank();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               $error("result word with nothing expected: %p", rsp_word);
               mismatches++;
            end else begin
               exp_word = due_words.pop_front();
               check_field("kind", exp_word.kind, rsp_word.kind);
               check_field("status", exp_word.status, rsp_word.status);
               check_field("fired_id", exp_word.fired_id, rsp_word.fired_id);
               check_field("timeout_count", exp_word.timeout_count, rsp_word.timeout_count);
               check_field("last", exp_word.last, rsp_word.last);
            end
         end
         if (req_valid && !req_stall) predict_words(req_word);
         if (csr_we) usable_ids = csr_wdata;
      end
      words_due <= due_words.size();
   end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sorted multi-timer testbench
// Drives set, cancel and tick words into the timer block under changing
// limits and handshake pressure; a checker beside it predicts every result.
// ---------------------------------------------------------------------------
module tb_top;
   import smt_pkg::*;

   // Cycles allowed for the block to finish a scan that produces no word,
   // such as a tick over a full list with nothing due.
   localparam int SETTLE_CYCLES = 60;
   localparam int SEG_ITEMS     = 25;
   localparam int NUM_SEGS      = 6;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_word_type     req_word  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_word_type     rsp_word;
   logic             csr_we    = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   int fail_count;
   int words_due;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int cur_limit     = TIMERS_IN_USE_RESET;

   sorted_multi_timer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   smt_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The result side stalls at random each cycle, at the rate set by the
   // current phase. A rate of zero gives no stall at all.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   function automatic req_word_type make_word(input logic [1:0] mode,
                                              input logic [ID_W-1:0] id,
                                              input logic [TMO_W-1:0] tmo);
      make_word.mode          = mode;
      make_word.timer_id      = id;
      make_word.timeout_ticks = tmo;
   endfunction

   // Offers one word and returns right after the edge that accepts it.
   // Random idle cycles come first, so valid is only lowered between words
   // and never dropped and raised again within one step.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering words and waits until every predicted word has come
   // back, then gives the block time to finish any silent tick scan.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The limit register is only written while the block is idle.
   task automatic write_limit(input logic [CFG_W-1:0] value);
      drain_block();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_limit  = value;
   endtask

   // Picks a timeout that is mostly short, so that timers really fire, with
   // some far expiries and the all-ones extreme mixed in.
   function automatic logic [TMO_W-1:0] pick_timeout();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return TMO_W'($urandom_range(5));
      if (roll < 90) return TMO_W'($urandom_range(40));
      if (roll < 97) return $urandom();
      return '1;
   endfunction

   // Ids mostly fall within the usable range so that sets and cancels get
   // past the limit check; the rest are drawn from all sixteen ids, which also probes the rejected ids.
   function automatic logic [ID_W-1:0] pick_id();
      int lim;
      lim = (cur_limit > MAX_IDS) ? MAX_IDS : cur_limit;
      if (lim == 0 || $urandom_range(99) < 15) return ID_W'($urandom_range(15));
      return ID_W'($urandom_range(lim - 1));
   endfunction

   task automatic send_random_word();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) begin
         send_word(make_word(MODE_SET, pick_id(), pick_timeout()));
      end else if (roll < 58) begin
         send_word(make_word(MODE_CANCEL, pick_id(), pick_timeout()));
      end else if (roll < 95) begin
         // The id and timeout of a tick are ignored; random values exercise that.
         send_word(make_word(MODE_TICK, ID_W'($urandom_range(15)), $urandom()));
      end else begin
         // Mode 3 is noise that the block must ignore entirely.
         send_word(make_word(2'd3, ID_W'($urandom_range(15)), $urandom()));
      end
   endtask

   initial begin
      logic [CFG_W-1:0] seg_limit [NUM_SEGS];
      seg_limit[0] = 5'd1;
      seg_limit[1] = 5'd31;
      seg_limit[2] = 5'd0;
      seg_limit[3] = 5'd7;
      seg_limit[4] = 5'd16;
      seg_limit[5] = CFG_W'($urandom_range(1, 16));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset limit of sixteen timers.
      // A tick with nothing armed gives no word at all.
      send_word(make_word(MODE_TICK, 4'd0, 32'd0));
      // A zero timeout fires on the very next tick.
      send_word(make_word(MODE_SET, 4'd0, 32'd0));
      // Setting a timer that is already armed is rejected.
      send_word(make_word(MODE_SET, 4'd0, 32'd5));
      send_word(make_word(MODE_SET, 4'd15, 32'hFFFF_FFFF));
      send_word(make_word(MODE_SET, 4'd5, 32'd3));
      // Equal expiry: timer 7 is placed ahead of timer 5 and fires first.
      send_word(make_word(MODE_SET, 4'd7, 32'd3));
      send_word(make_word(MODE_SET, 4'd9, 32'd1));
      // Cancelling an idle timer is rejected; cancelling an armed one is not.
      send_word(make_word(MODE_CANCEL, 4'd2, 32'd0));
      send_word(make_word(MODE_CANCEL, 4'd15, 32'hFFFF_FFFF));
      send_word(make_word(MODE_CANCEL, 4'd15, 32'd0));
      send_word(make_word(MODE_TICK, 4'd15, 32'hFFFF_FFFF));
      send_word(make_word(2'd3, 4'd15, 32'hFFFF_FFFF));
      send_word(make_word(MODE_TICK, 4'd0, 32'd0));
      send_word(make_word(MODE_TICK, 4'd0, 32'd0));
      // The reply to a fresh set carries the count of earlier expiries.
      send_word(make_word(MODE_SET, 4'd0, 32'd0));
      send_word(make_word(MODE_SET, 4'd3, 32'd2));
      send_word(make_word(MODE_SET, 4'd12, 32'h8000_0000));
      send_word(make_word(MODE_TICK, 4'd0, 32'd0));
      send_word(make_word(MODE_TICK, 4'd0, 32'd0));
      send_word(make_word(MODE_TICK, 4'd0, 32'd0));
      send_word(make_word(MODE_CANCEL, 4'd12, 32'd0));

      // Random part: each segment runs under its own limit; the handshake
      // pressure changes every two segments.
      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         write_limit(seg_limit[seg]);
         case (seg / 2)
            0: begin
               send_idle_pct = 14;
               rsp_idle_pct  = 60;
            end
            1: begin
               send_idle_pct = 60;
               rsp_idle_pct  = 14;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         // With every id usable, arm the whole bank at nearly the same time
         // so that one tick can fire up to sixteen timers at once.
         if (seg_limit[seg] >= MAX_IDS) begin
            for (int k = 0; k < MAX_IDS; k++) begin
               send_word(make_word(MODE_SET, ID_W'(k), TMO_W'($urandom_range(1))));
            end
         end
         for (int n = 0; n < SEG_ITEMS; n++) send_random_word();
      end

      drain_block();
      if (fail_count == 0 && words_due == 0) begin
         $display("[sorted_multi_timer] OK");
      end else begin
         $display("[sorted_multi_timer] ERROR");
      end
      $finish;
   end

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #(5_000_000);
      $display("[sorted_multi_timer] ERROR");
      $finish;
   end

endmodule

[sim.f]
src/smt_pkg.sv
src/smt_ram.sv
src/smt_arith.sv
src/sorted_multi_timer.sv
verif/smt_checker.sv
verif/tb_top.sv
